// ===== sv/abd_pkg.sv =====
package abd_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int LEN_WIDTH   = 30;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   localparam logic [1:0] KIND_UNKNOWN    = 2'd0;
   localparam logic [1:0] KIND_INDEFINITE = 2'd1;
   localparam logic [1:0] KIND_DEFINITE   = 2'd2;
   localparam logic [1:0] KIND_OTHER      = 2'd3;

   localparam logic [2:0] STATUS_OK             = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT      = 3'd1;
   localparam logic [2:0] STATUS_INDEF_DENIED   = 3'd2;
   localparam logic [2:0] STATUS_DEF_DENIED     = 3'd3;
   localparam logic [2:0] STATUS_LEN_TRUNCATED  = 3'd4;
   localparam logic [2:0] STATUS_LEN_TOO_LARGE  = 3'd5;
   localparam logic [2:0] STATUS_GARBLED        = 3'd6;

   localparam int MODE_DECODE_INDEF = 0;
   localparam int MODE_VERIFY_INDEF = 1;
   localparam int MODE_DECODE_DEF   = 2;
   localparam int MODE_VERIFY_DEF   = 3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       message_done;
      logic [2:0] status;
      logic       run_last;
   } rsp_type;

endpackage

// ===== sv/arbitrary_block_deframer_core.sv =====
// a result beat is written into the result queue when its request beat is accepted and is offered from its head
// throughput: one request beat per cycle while each beat yields at most one result and the result
//   side keeps taking; a beat that yields two results needs two pops of the single result port
// a four-entry result queue decouples the two sides; req_ready is decoded from registered state
// reset: synchronous, active high; clears mode flags, parser state and the queue
module arbitrary_block_deframer_core
   import abd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // mode register
   logic [3:0] mode_ff;

   // parser state
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [1:0]             kind_ff, kind_in;
   logic [7:0]             first_ff, first_in;
   logic [3:0]             ldc_ff, ldc_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic                   len_ended_ff, len_ended_in;
   logic [LEN_WIDTH-1:0]   seen_ff, seen_in;
   logic [7:0]             held_ff, held_in;
   logic                   held_valid_ff, held_valid_in;

   // result queue
   rsp_type                queue_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;

   // per-beat results
   rsp_type    slot [2];
   logic [1:0] res_n;

   logic req_fire, rsp_fire;
   logic [7:0] b;
   logic       eom;

   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign b         = req_payload.rx_byte;
   assign eom       = req_payload.end_of_message;

   // room for two results without counting on a pop this cycle
   assign req_ready   = (count_ff <= QCNT_WIDTH'(QUEUE_DEPTH - 2));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

   always_comb begin
      logic                 idx0, idx1;
      logic [1:0]           kind_now;
      logic                 dec;
      logic [3:0]           digits;
      logic                 is_digit;
      logic [LEN_WIDTH-1:0] len_x10;
      logic [2:0]           st;
      logic                 last;

      byte_count_in = byte_count_ff;
      kind_in       = kind_ff;
      first_in      = first_ff;
      ldc_in        = ldc_ff;
      len_in        = len_ff;
      len_ended_in  = len_ended_ff;
      seen_in       = seen_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      slot[0]       = '0;
      slot[1]       = '0;
      res_n         = 2'd0;
      st            = STATUS_OK;
      last          = 1'b0;

      idx0     = (byte_count_ff == '0);
      idx1     = (byte_count_ff == COUNT_WIDTH'(1));
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      digits   = 4'(first_ff - CHAR_ZERO);
      len_x10  = (len_ff << 3) + (len_ff << 1) + LEN_WIDTH'(b - CHAR_ZERO);

      // header kind is settled by the second byte
      if (idx1) begin
         if (first_ff == CHAR_HASH && b == CHAR_ZERO)
            kind_now = KIND_INDEFINITE;
         else if (first_ff == CHAR_HASH && b >= CHAR_ONE && b <= CHAR_NINE)
            kind_now = KIND_DEFINITE;
         else
            kind_now = KIND_OTHER;
      end else begin
         kind_now = kind_ff;
      end

      case (kind_now)
         KIND_INDEFINITE: dec = mode_ff[MODE_DECODE_INDEF];
         KIND_DEFINITE:   dec = mode_ff[MODE_DECODE_DEF];
         default:         dec = 1'b0;
      endcase

      if (idx0) begin
         first_in = b;
         if (eom) begin
            slot[0] = '{has_byte: 1'b1, out_byte: b, default: '0};
            res_n   = 2'd1;
         end
      end else if (idx1) begin
         kind_in  = kind_now;
         first_in = b;
         if (!dec) begin
            slot[0] = '{has_byte: 1'b1, out_byte: first_ff, default: '0};
            slot[1] = '{has_byte: 1'b1, out_byte: b, default: '0};
            res_n   = 2'd2;
         end
      end else if (kind_ff == KIND_INDEFINITE) begin
         // one-byte delay lets the closing newline be withheld
         if (held_valid_ff) begin
            slot[0] = '{has_byte: 1'b1, out_byte: held_ff, default: '0};
            res_n   = 2'd1;
         end
         if (dec) begin
            held_in       = b;
            held_valid_in = 1'b1;
         end else begin
            held_valid_in    = 1'b0;
            slot[res_n[0]]   = '{has_byte: 1'b1, out_byte: b, default: '0};
            res_n            = res_n + 2'd1;
         end
      end else if (kind_ff == KIND_DEFINITE) begin
         if (ldc_ff < digits) begin
            if (!len_ended_ff && is_digit)
               len_in = len_x10;
            else
               len_ended_in = 1'b1;
            ldc_in = ldc_ff + 4'd1;
            if (!dec) begin
               slot[0] = '{has_byte: 1'b1, out_byte: b, default: '0};
               res_n   = 2'd1;
            end
         end else if (seen_ff < len_ff) begin
            seen_in = seen_ff + LEN_WIDTH'(1);
            slot[0] = '{has_byte: 1'b1, out_byte: b, default: '0};
            res_n   = 2'd1;
         end else if (!dec) begin
            // surplus bytes pass only in pass-through
            slot[0] = '{has_byte: 1'b1, out_byte: b, default: '0};
            res_n   = 2'd1;
         end
      end else begin
         slot[0] = '{has_byte: 1'b1, out_byte: b, default: '0};
         res_n   = 2'd1;
      end

      if (eom) begin
         if (idx0 || idx1)
            st = STATUS_TOO_SHORT;
         else if (kind_ff == KIND_INDEFINITE && b == CHAR_NEWLINE)
            st = (mode_ff[MODE_DECODE_INDEF] | mode_ff[MODE_VERIFY_INDEF]) ?
                 STATUS_OK : STATUS_INDEF_DENIED;
         else if (kind_ff == KIND_DEFINITE) begin
            if (!(mode_ff[MODE_DECODE_DEF] | mode_ff[MODE_VERIFY_DEF]))
               st = STATUS_DEF_DENIED;
            else if (ldc_in < digits)
               st = STATUS_LEN_TRUNCATED;
            else if (seen_in < len_in)
               st = STATUS_LEN_TOO_LARGE;
            else
               st = STATUS_OK;
         end else
            st = STATUS_GARBLED;

         // empty closing beat when nothing else came out
         if (res_n == 2'd0) begin
            slot[0] = '0;
            res_n   = 2'd1;
         end
         last                     = (res_n == 2'd2);
         slot[last].message_done  = 1'b1;
         slot[last].status        = st;

         byte_count_in = '0;
         kind_in       = KIND_UNKNOWN;
         first_in      = '0;
         ldc_in        = '0;
         len_in        = '0;
         len_ended_in  = 1'b0;
         seen_in       = '0;
         held_in       = '0;
         held_valid_in = 1'b0;
      end else if (byte_count_ff != COUNT_MAX) begin
         byte_count_in = byte_count_ff + COUNT_WIDTH'(1);
      end

      if (res_n != 2'd0) begin
         last                 = (res_n == 2'd2);
         slot[last].run_last  = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire)
         count_in = count_in + QCNT_WIDTH'(res_n);
      if (rsp_fire)
         count_in = count_in - QCNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         byte_count_ff <= '0;
         kind_ff       <= KIND_UNKNOWN;
         first_ff      <= '0;
         ldc_ff        <= '0;
         len_ff        <= '0;
         len_ended_ff  <= 1'b0;
         seen_ff       <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_wr_en)
            mode_ff <= csr_wr_data;
         if (req_fire) begin
            byte_count_ff <= byte_count_in;
            kind_ff       <= kind_in;
            first_ff      <= first_in;
            ldc_ff        <= ldc_in;
            len_ff        <= len_in;
            len_ended_ff  <= len_ended_in;
            seen_ff       <= seen_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
            wr_ptr_ff     <= wr_ptr_ff + QPTR_WIDTH'(res_n);
         end
         if (rsp_fire)
            rd_ptr_ff <= rd_ptr_ff + QPTR_WIDTH'(1);
         count_ff <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (res_n != 2'd0)
            queue_ff[wr_ptr_ff] <= slot[0];
         if (res_n == 2'd2)
            queue_ff[wr_ptr_ff + QPTR_WIDTH'(1)] <= slot[1];
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_eom_yields_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && eom |-> res_n != 2'd0)
      else $error("closing beat produced no result");

   a_eom_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && eom |=> byte_count_ff == '0 && kind_ff == KIND_UNKNOWN)
      else $error("message state not cleared after last beat");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.message_done |-> rsp_payload.run_last)
      else $error("message_done without run_last");

   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.message_done |-> rsp_payload.status == STATUS_OK)
      else $error("status outside closing beat");
`endif

endmodule

// ===== tb/deframer_checker.sv =====
`timescale 1ns / 1ps

module deframer_checker
   import abd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   output int         owed,
   output int         fail_count,
   output int         results_seen,
   output int         messages_seen,
   output logic [6:0] status_seen
);

   // local copy of the mode register and the message parse
   logic [3:0]             mode;
   logic [COUNT_WIDTH-1:0] pos;
   logic [1:0]             kind;
   logic [7:0]             prev_byte;
   logic [3:0]             len_digits;
   logic [LEN_WIDTH-1:0]   len_val;
   logic                   len_stop;
   logic [LEN_WIDTH-1:0]   data_seen;
   logic [7:0]             held;
   logic                   held_ok;

   rsp_type    owed_results[$];
   int         fails;
   int         results;
   int         messages;
   logic [6:0] statuses;

   task automatic clear_message;
      pos        = '0;
      kind       = KIND_UNKNOWN;
      prev_byte  = '0;
      len_digits = '0;
      len_val    = '0;
      len_stop   = 1'b0;
      data_seen  = '0;
      held       = '0;
      held_ok    = 1'b0;
   endtask

   function automatic logic decoding();
      if (kind == KIND_INDEFINITE) return mode[MODE_DECODE_INDEF];
      if (kind == KIND_DEFINITE) return mode[MODE_DECODE_DEF];
      return 1'b0;
   endfunction

   // number of length digits announced by the digit after '#'
   function automatic logic [7:0] field_width();
      return prev_byte - CHAR_ZERO;
   endfunction

   function automatic rsp_type byte_beat(input logic [7:0] b, input logic has);
      rsp_type r;
      r          = '0;
      r.has_byte = has;
      r.out_byte = has ? b : 8'h00;
      return r;
   endfunction

   task automatic deframe_byte(input req_type beat);
      rsp_type                outs[2];
      int                     n;
      int                     i;
      logic [7:0]             b;
      logic [COUNT_WIDTH-1:0] idx;
      logic [2:0]             st;
      logic                   dec;
      n   = 0;
      b   = beat.rx_byte;
      idx = pos;
      if (idx == 0) begin
         prev_byte = b;
         if (beat.end_of_message) begin
            outs[n] = byte_beat(b, 1'b1);
            n++;
         end
      end else if (idx == 1) begin
         if (prev_byte == CHAR_HASH && b == CHAR_ZERO)
            kind = KIND_INDEFINITE;
         else if (prev_byte == CHAR_HASH && b >= CHAR_ONE && b <= CHAR_NINE)
            kind = KIND_DEFINITE;
         else
            kind = KIND_OTHER;
         if (!decoding()) begin
            outs[0] = byte_beat(prev_byte, 1'b1);
            outs[1] = byte_beat(b, 1'b1);
            n = 2;
         end
         prev_byte = b;
      end else if (kind == KIND_INDEFINITE) begin
         if (held_ok) begin
            outs[n] = byte_beat(held, 1'b1);
            n++;
         end
         if (decoding()) begin
            held    = b;
            held_ok = 1'b1;
         end else begin
            held_ok = 1'b0;
            outs[n] = byte_beat(b, 1'b1);
            n++;
         end
      end else if (kind == KIND_DEFINITE) begin
         dec = decoding();
         if (len_digits < field_width()) begin
            if (!len_stop && b >= CHAR_ZERO && b <= CHAR_NINE)
               len_val = LEN_WIDTH'(len_val * 10 + LEN_WIDTH'(b - CHAR_ZERO));
            else
               len_stop = 1'b1;
            len_digits++;
            if (!dec) begin
               outs[n] = byte_beat(b, 1'b1);
               n++;
            end
         end else if (data_seen < len_val) begin
            data_seen++;
            outs[n] = byte_beat(b, 1'b1);
            n++;
         end else if (!dec) begin
            outs[n] = byte_beat(b, 1'b1);
            n++;
         end
      end else begin
         outs[n] = byte_beat(b, 1'b1);
         n++;
      end

      if (beat.end_of_message) begin
         if (idx < 2)
            st = STATUS_TOO_SHORT;
         else if (kind == KIND_INDEFINITE && b == CHAR_NEWLINE)
            st = (mode[1:0] != 2'b00) ? STATUS_OK : STATUS_INDEF_DENIED;
         else if (kind == KIND_DEFINITE) begin
            if (mode[3:2] == 2'b00)
               st = STATUS_DEF_DENIED;
            else if (len_digits < field_width())
               st = STATUS_LEN_TRUNCATED;
            else if (data_seen < len_val)
               st = STATUS_LEN_TOO_LARGE;
            else
               st = STATUS_OK;
         end else
            st = STATUS_GARBLED;
         if (n == 0) begin
            outs[0] = byte_beat(8'h00, 1'b0);
            n = 1;
         end
         outs[n-1].message_done = 1'b1;
         outs[n-1].status       = st;
         clear_message();
      end else if (pos != '1) begin
         pos++;
      end

      if (n > 0) outs[n-1].run_last = 1'b1;
      for (i = 0; i < n; i++) owed_results.push_back(outs[i]);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         mode = 4'h0;
         clear_message();
         owed_results.delete();
         fails    = 0;
         results  = 0;
         messages = 0;
         statuses = '0;
      end else begin
         if (csr_wr_en) mode = csr_wr_data;
         if (req_valid && req_ready) deframe_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            results++;
            if (owed_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display({"%0t: unexpected result beat has=%0d byte=%02h ",
                            "done=%0d st=%0d last=%0d"},
                           $time, rsp_payload.has_byte, rsp_payload.out_byte,
                           rsp_payload.message_done, rsp_payload.status,
                           rsp_payload.run_last);
            end else begin
               want = owed_results.pop_front();
               if (want.message_done) begin
                  messages++;
                  statuses[want.status] = 1'b1;
               end
               if (rsp_payload.has_byte !== want.has_byte ||
                   rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.message_done !== want.message_done ||
                   rsp_payload.status !== want.status ||
                   rsp_payload.run_last !== want.run_last) begin
                  fails++;
                  if (fails <= 10)
                     $display({"%0t: result mismatch want has=%0d byte=%02h ",
                               "done=%0d st=%0d last=%0d, ",
                               "got has=%0d byte=%02h done=%0d st=%0d last=%0d"},
                              $time, want.has_byte, want.out_byte, want.message_done,
                              want.status, want.run_last, rsp_payload.has_byte,
                              rsp_payload.out_byte, rsp_payload.message_done,
                              rsp_payload.status, rsp_payload.run_last);
               end
            end
         end
      end
      owed          <= owed_results.size();
      fail_count    <= fails;
      results_seen  <= results;
      messages_seen <= messages;
      status_seen   <= statuses;
   end

endmodule

// ===== tb/arbitrary_block_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module arbitrary_block_deframer_core_tb;
   import abd_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_wr_en = 1'b0;
   logic [3:0] csr_wr_data = 4'h0;

   // figures handed up by the checker
   int         owed;
   int         fail_count;
   int         results_seen;
   int         messages_seen;
   logic [6:0] status_seen;

   // no idling on either side while set
   logic       steady = 1'b0;
   int         beats_sent = 0;
   int         mode_writes = 0;

   // message bytes waiting to go out, eom goes with the last one
   logic [7:0] frame[$];

   always #2 clock = ~clock;

   arbitrary_block_deframer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   deframer_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .owed          (owed),
      .fail_count    (fail_count),
      .results_seen  (results_seen),
      .messages_seen (messages_seen),
      .status_seen   (status_seen)
   );

   // result side stalls with a chance of about 7 in 100 unless steady
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 7);
   end

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // one request beat, with random gaps before it; valid stays up after acceptance
   // so back-to-back beats never drop valid in between
   task automatic send_beat(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{rx_byte: b, end_of_message: last};
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // hold off the sender until every owed result beat is back, then let the
   // pipeline settle, since a beat that yields nothing may still be in flight
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (owed != 0);
      repeat (4) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_mode(input logic [3:0] m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mode_writes++;
   endtask

   // send the frame; at index split the mode is rewritten mid-message
   task automatic send_frame(input int split, input logic [3:0] split_mode);
      int i;
      for (i = 0; i < frame.size(); i++) begin
         if (i == split) begin
            drain_results();
            write_mode(split_mode);
         end
         send_beat(frame[i], i == frame.size() - 1);
      end
   endtask

   task automatic send_random_message;
      int         pick;
      int         width;
      int         len;
      int         tmp;
      int         flavor;
      int         i;
      int         cut;
      int         split;
      logic [7:0] b;
      logic [7:0] digits[9];
      frame = {};
      pick  = $urandom_range(99);
      if (pick < 40) begin
         // definite block, mostly short data, a few long ones
         width = $urandom_range(1, 9);
         len   = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
         frame.push_back(CHAR_HASH);
         frame.push_back(CHAR_ZERO + width[7:0]);
         tmp = len;
         for (i = width - 1; i >= 0; i--) begin
            digits[i] = CHAR_ZERO + 8'(tmp % 10);
            tmp       = tmp / 10;
         end
         flavor = $urandom_range(99);
         if (flavor >= 70 && flavor < 80) begin
            // a non-digit ends the length early
            i = $urandom_range(0, width - 1);
            do b = any_byte(); while (b >= CHAR_ZERO && b <= CHAR_NINE);
            digits[i] = b;
         end else if (flavor >= 90) begin
            // declared length mostly far past the data
            for (i = 0; i < width; i++) digits[i] = CHAR_ZERO + 8'($urandom_range(0, 9));
         end
         for (i = 0; i < width; i++) frame.push_back(digits[i]);
         for (i = 0; i < len; i++) frame.push_back(any_byte());
         // surplus data after the declared length
         if (flavor < 70 && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) frame.push_back(any_byte());
         // cut short in the length field or the data
         if (flavor >= 80 && flavor < 90) begin
            cut = $urandom_range(3, frame.size());
            while (frame.size() > cut) void'(frame.pop_back());
         end
      end else if (pick < 70) begin
         // indefinite block, sometimes missing the closing newline
         frame.push_back(CHAR_HASH);
         frame.push_back(CHAR_ZERO);
         repeat ($urandom_range(0, 10)) frame.push_back(any_byte());
         frame.push_back(($urandom_range(9) == 0) ? any_byte() : CHAR_NEWLINE);
      end else if (pick < 80) begin
         // one or two byte messages, often a bare header
         b = ($urandom_range(1) == 0) ? CHAR_HASH : any_byte();
         frame.push_back(b);
         if ($urandom_range(1) == 0) begin
            tmp = $urandom_range(2);
            case (tmp)
               0: frame.push_back(CHAR_ZERO);
               1: frame.push_back(CHAR_ONE + 8'($urandom_range(0, 8)));
               default: frame.push_back(any_byte());
            endcase
         end
      end else begin
         // noise, half of it behind a '#'
         repeat ($urandom_range(2, 8)) frame.push_back(any_byte());
         if ($urandom_range(1) == 0) frame[0] = CHAR_HASH;
      end
      split = ($urandom_range(99) < 3 && frame.size() > 1) ?
              $urandom_range(1, frame.size() - 1) : -1;
      send_frame(split, 4'($urandom_range(0, 15)));
   endtask

   initial begin : stimulus
      int         phase;
      int         phase_start;
      logic [3:0] m;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: mode still at reset value, everything passes through
      frame = '{8'hFF};                      // lone byte, too short
      send_frame(-1, 4'h0);
      frame = '{8'h61, 8'h62};               // not a block header
      send_frame(-1, 4'h0);

      drain_results();
      write_mode(4'hF);
      frame = '{CHAR_HASH, CHAR_ZERO, 8'h00, CHAR_NEWLINE};
      send_frame(-1, 4'h0);
      // one length digit, two data bytes, surplus byte dropped, closing beat empty
      frame = '{CHAR_HASH, CHAR_ONE, 8'h32, 8'h00, 8'hFF, 8'h55};
      send_frame(-1, 4'h0);
      // non-digit first in a two digit field, field left unfinished
      frame = '{CHAR_HASH, 8'h32, 8'h78};
      send_frame(-1, 4'h0);
      // declares nine data bytes, sends none
      frame = '{CHAR_HASH, CHAR_ONE, CHAR_NINE};
      send_frame(-1, 4'h0);
      // decode switched off mid-message: held byte comes out late
      frame = '{CHAR_HASH, CHAR_ZERO, 8'h71, 8'h72, CHAR_NEWLINE};
      send_frame(3, 4'h0);

      drain_results();
      write_mode(4'h3);
      frame = '{CHAR_HASH, CHAR_ONE};        // definite not allowed
      send_frame(-1, 4'h0);

      // random phases, each opened with one mode setting, the extremes first; a split message may rewrite it
      for (phase = 0; phase < 9; phase++) begin
         drain_results();
         case (phase)
            0: m = 4'hF;
            1: m = 4'h0;
            2: m = 4'h5;
            3: m = 4'hA;
            default: m = 4'($urandom_range(0, 15));
         endcase
         write_mode(m);
         steady <= (phase == 4);
         phase_start = beats_sent;
         while (beats_sent - phase_start < 162) send_random_message();
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("sent %0d request beats over %0d mode writes;", beats_sent, mode_writes);
      $display("%0d result beats checked, %0d messages closed", results_seen, messages_seen);
      $display("closing status codes hit, one bit per code: %b", status_seen);
      if (fail_count == 0 && owed == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog, far beyond any correct run
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== arbitrary_block_deframer_core.f =====
sv/abd_pkg.sv
sv/arbitrary_block_deframer_core.sv
tb/deframer_checker.sv
tb/arbitrary_block_deframer_core_tb.sv
